// ----- rtl/core/chd_pkg.sv -----
// chd_pkg: shared types, request and status codes, field widths
// for the canonical huffman decoder; no dependencies
package chd_pkg;

  localparam int REQ_W   = 3;
  localparam int CNT_W   = 9;
  localparam int SYM_W   = 8;
  localparam int LEN_W   = 5;
  localparam int STAT_W  = 2;
  localparam int ACC_W   = 16;
  localparam int CODE_W  = 17;

  localparam int DEF_MAX_CODE_LEN = 16;
  localparam int DEF_MAX_SYMBOLS  = 256;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 3'd0,
    REQ_ROW    = 3'd1,
    REQ_LOAD   = 3'd2,
    REQ_DECODE = 3'd3,
    REQ_EOS    = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SYMBOL = 2'd1,
    ST_EOS       = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

endpackage

// ----- rtl/core/chd_if.sv -----
// chd_in_if / chd_out_if: valid-ready channels of the huffman decoder
// depends on chd_pkg for field widths
interface chd_in_if import chd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [CNT_W-1:0] row_count;
  logic [SYM_W-1:0] symbol_in;
  logic             code_bit;

  modport source (output valid, req_type, row_count, symbol_in, code_bit, input ready);
  modport sink   (input valid, req_type, row_count, symbol_in, code_bit, output ready);
endinterface

interface chd_out_if import chd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SYM_W-1:0]  symbol_out;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, status, symbol_out, code_length, input ready);
  modport sink   (input valid, status, symbol_out, code_length, output ready);
endinterface

// ----- rtl/core/canonical_huffman_decoder_unit.sv -----
// canonical_huffman_decoder_unit: jpeg-style canonical huffman table builder
// and bit-serial decoder; depends on chd_pkg and the chd_in_if/chd_out_if channels
//
//   channel  dir  handshake       payload
//   in_i     in   valid / ready   req_type, row_count, symbol_in, code_bit
//   out_o    out  valid / ready   status, symbol_out, code_length
//
// one item per cycle unless a result finds the result register full: an accepted
// item sits in the input register, is executed against the table and its result
// lands in the result register; result valid and the symbol byte, a registered
// read of the symbol memory, are set at the same edge
// an item holds in the input register only while its result would find the
// result register still full; items with no result never wait on the output
// reset clears all control state and the per-length rows; the symbol memory
// is not cleared and needs no clearing pass
module canonical_huffman_decoder_unit import chd_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int MAX_SYMBOLS  = DEF_MAX_SYMBOLS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  chd_in_if.sink    in_i,
  chd_out_if.source out_o
);

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int RW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_CODE_LEN);
  localparam logic [CNT_W:0]   MaxSym = (CNT_W+1)'(MAX_SYMBOLS);

  // input register
  logic             ex_valid_q;
  logic [REQ_W-1:0] ex_req_q;
  logic [CNT_W-1:0] ex_cnt_q;
  logic [SYM_W-1:0] ex_sym_q;
  logic             ex_bit_q;

  // decoder state
  logic [ACC_W-1:0]  accum_q, accum_d;
  logic [LEN_W-1:0]  bits_q, bits_d;
  logic [LEN_W-1:0]  rows_q, rows_d;
  logic [CODE_W-1:0] free_q, free_d;
  logic [CNT_W-1:0]  loaded_q, loaded_d;
  logic [CNT_W-1:0]  pending_q, pending_d;

  // per-length rows, indexed by code length minus one
  logic [CODE_W-1:0] first_q [MAX_CODE_LEN];
  logic [CNT_W-1:0]  count_q [MAX_CODE_LEN];
  logic [CNT_W-1:0]  base_q  [MAX_CODE_LEN];

  // symbol memory
  logic [SYM_W-1:0] mem [MAX_SYMBOLS];
  logic [SYM_W-1:0] rd_q;

  // result register
  logic              res_valid_q;
  logic [STAT_W-1:0] res_status_q;
  logic [LEN_W-1:0]  res_len_q;
  logic              res_match_q;

  // execute stage signals
  logic              ex_has_res;
  logic              ex_fire;
  logic              res_free;
  logic              clear_all;
  logic              row_we;
  logic [RW-1:0]     row_wsel;
  logic [CODE_W-1:0] row_first_w;
  logic [CNT_W-1:0]  row_cnt_w;
  logic [CNT_W-1:0]  row_base_w;
  logic              mem_we;
  logic [AW-1:0]     rd_addr;
  status_e           res_status;
  logic [LEN_W-1:0]  res_len;
  logic              res_match;

  // row build intermediates
  logic [CNT_W:0]    committed;
  logic [CODE_W-1:0] free_code;
  logic [LEN_W-1:0]  new_len;
  logic [CODE_W:0]   pow_len;
  logic [CODE_W:0]   avail;
  logic              row_bad;

  // decode intermediates
  logic [ACC_W-1:0]  acc_new;
  logic [LEN_W-1:0]  dec_len;
  logic [RW-1:0]     dec_sel;
  logic [CODE_W-1:0] dec_diff;
  logic [CNT_W-1:0]  dec_pos;
  logic              dec_hit;

  assign res_free = !res_valid_q || out_o.ready;
  assign ex_fire  = ex_valid_q && (!ex_has_res || res_free);
  assign in_i.ready = !ex_valid_q || ex_fire;

  // next-row arithmetic: first code of the new length and what is still free
  assign committed = {1'b0, loaded_q} + {1'b0, pending_q};
  assign free_code = {free_q[CODE_W-2:0], 1'b0};
  assign new_len   = rows_q + LEN_W'(1);
  assign pow_len   = (CODE_W+1)'(1) << new_len;
  assign avail     = (pow_len > {1'b0, free_code}) ? pow_len - {1'b0, free_code}
                                                   : '0;
  assign row_bad   = ({{(CODE_W+1-CNT_W){1'b0}}, ex_cnt_q} > avail) ||
                     (committed + {1'b0, ex_cnt_q} > MaxSym);

  // decode arithmetic: compare the grown code against its length's row
  assign acc_new  = {accum_q[ACC_W-2:0], ex_bit_q};
  assign dec_len  = bits_q + LEN_W'(1);
  assign dec_sel  = bits_q[RW-1:0];
  assign dec_diff = {1'b0, acc_new} - first_q[dec_sel];
  assign dec_hit  = (dec_len <= rows_q) &&
                    ({1'b0, acc_new} >= first_q[dec_sel]) &&
                    (dec_diff < {{(CODE_W-CNT_W){1'b0}}, count_q[dec_sel]});
  assign dec_pos  = base_q[dec_sel] + dec_diff[CNT_W-1:0];
  assign rd_addr  = dec_pos[AW-1:0];

  always_comb begin
    accum_d     = accum_q;
    bits_d      = bits_q;
    rows_d      = rows_q;
    free_d      = free_q;
    loaded_d    = loaded_q;
    pending_d   = pending_q;
    clear_all   = 1'b0;
    row_we      = 1'b0;
    row_wsel    = rows_q[RW-1:0];
    row_first_w = free_code;
    row_cnt_w   = '0;
    row_base_w  = committed[CNT_W-1:0];
    mem_we      = 1'b0;
    ex_has_res  = 1'b0;
    res_status  = ST_OK;
    res_len     = '0;
    res_match   = 1'b0;
    case (req_e'(ex_req_q))
      REQ_CLEAR: begin
        clear_all = 1'b1;
        accum_d   = '0;
        bits_d    = '0;
        rows_d    = '0;
        free_d    = '0;
        loaded_d  = '0;
        pending_d = '0;
      end
      REQ_ROW: begin
        // abandoned loads of the previous row still take their slots
        ex_has_res = 1'b1;
        loaded_d   = committed[CNT_W-1:0];
        pending_d  = '0;
        if (rows_q >= MaxLen) begin
          res_status = ST_OVERFLOW;
        end else begin
          rows_d = new_len;
          row_we = 1'b1;
          if (row_bad) begin
            // overflowed row stays empty and leaves its codes free
            res_status = ST_OVERFLOW;
            free_d     = free_code;
          end else begin
            row_cnt_w = ex_cnt_q;
            free_d    = free_code + {{(CODE_W-CNT_W){1'b0}}, ex_cnt_q};
            pending_d = ex_cnt_q;
          end
        end
      end
      REQ_LOAD: begin
        if (pending_q != '0 && {1'b0, loaded_q} < MaxSym) begin
          mem_we    = 1'b1;
          loaded_d  = loaded_q + CNT_W'(1);
          pending_d = pending_q - CNT_W'(1);
        end
      end
      REQ_DECODE: begin
        accum_d = acc_new;
        bits_d  = dec_len;
        if (dec_hit) begin
          ex_has_res = 1'b1;
          res_match  = 1'b1;
          res_len    = dec_len;
          accum_d    = '0;
          bits_d     = '0;
        end else if (dec_len >= rows_q) begin
          // ran past the longest row
          ex_has_res = 1'b1;
          res_status = ST_NO_SYMBOL;
          accum_d    = '0;
          bits_d     = '0;
        end
      end
      REQ_EOS: begin
        ex_has_res = 1'b1;
        res_status = ST_EOS;
        accum_d    = '0;
        bits_d     = '0;
      end
      default: begin
      end
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      ex_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ex_req_q <= in_i.req_type;
      ex_cnt_q <= in_i.row_count;
      ex_sym_q <= in_i.symbol_in;
      ex_bit_q <= in_i.code_bit;
    end
  end

  // decoder state, advanced once per executed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q   <= '0;
      bits_q    <= '0;
      rows_q    <= '0;
      free_q    <= '0;
      loaded_q  <= '0;
      pending_q <= '0;
    end else if (ex_fire) begin
      accum_q   <= accum_d;
      bits_q    <= bits_d;
      rows_q    <= rows_d;
      free_q    <= free_d;
      loaded_q  <= loaded_d;
      pending_q <= pending_d;
    end
  end

  // per-length rows; clear wipes all of them together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        first_q[i] <= '0;
        count_q[i] <= '0;
        base_q[i]  <= '0;
      end
    end else if (ex_fire && clear_all) begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        first_q[i] <= '0;
        count_q[i] <= '0;
        base_q[i]  <= '0;
      end
    end else if (ex_fire && row_we) begin
      first_q[row_wsel] <= row_first_w;
      count_q[row_wsel] <= row_cnt_w;
      base_q[row_wsel]  <= row_base_w;
    end
  end

  // symbol memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ex_fire && mem_we) begin
      mem[loaded_q[AW-1:0]] <= ex_sym_q;
    end
    if (ex_fire && res_match) begin
      rd_q <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ex_fire && ex_has_res) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire && ex_has_res) begin
      res_status_q <= res_status;
      res_len_q    <= res_len;
      res_match_q  <= res_match;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.status      = res_status_q;
  assign out_o.code_length = res_len_q;
  assign out_o.symbol_out  = res_match_q ? rd_q : '0;

`ifndef SYNTH
  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= LEN_W'(ACC_W))
    else $error("code bit count past the longest code");

  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q <= MaxLen)
    else $error("more rows built than code lengths");

  a_sym_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, loaded_q} + {1'b0, pending_q}) <= MaxSym)
    else $error("symbol slots committed past the store");

  a_len_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_OK |-> out_o.code_length == '0)
    else $error("code length given on a non-symbol result");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_valid_q && !ex_fire |=> ex_valid_q && $stable(ex_req_q))
    else $error("stalled item lost from the input register");
`endif

endmodule
